FILE: hdl/arpc_pkg.sv
package arpc_pkg;

   // Table size default and fixed field widths
   localparam int CACHE_ENTRIES_DEF = 16;
   localparam int IP_W              = 32;
   localparam int MAC_W             = 48;
   localparam int ENTRY_W           = IP_W + MAC_W;
   localparam int CSR_IDX_W         = 1;
   localparam int CSR_DATA_W        = 48;

   // Command queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // Header checks
   localparam logic [10:0] HDR_BYTES   = 11'd28;
   localparam logic [15:0] HTYPE_ETH   = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
   localparam logic [15:0] OPC_REQUEST = 16'h0001;

   // Operation codes
   localparam logic [1:0] OP_RECEIVE = 2'd0;
   localparam logic [1:0] OP_LOOKUP  = 2'd1;
   localparam logic [1:0] OP_INSERT  = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   // Drop codes
   localparam logic [1:0] DROP_NONE  = 2'd0;
   localparam logic [1:0] DROP_RUNT  = 2'd1;
   localparam logic [1:0] DROP_HTYPE = 2'd2;
   localparam logic [1:0] DROP_PTYPE = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP = 1'd0;

   typedef enum logic [1:0] {
      CMD_FIXED  = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_STORE  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]       drop_code;
      logic             table_ok;
      logic             reply_send;
      logic [MAC_W-1:0] reply_dest_mac;
      logic [MAC_W-1:0] reply_target_mac;
      logic [IP_W-1:0]  reply_target_ip;
      logic             lookup_hit;
      logic [MAC_W-1:0] lookup_mac;
   } result_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IP_W-1:0]  key_ip;
      logic [MAC_W-1:0] mac;
      result_type       base;
   } cmd_type;

endpackage

FILE: hdl/arp_cache_and_responder.sv
// ARP responder with an IPv4-to-MAC binding cache.
//
// Request channel (req_*): one item carries an operation: receive a parsed
// ARP header, look up sender_ip, or insert a binding. Response channel
// (rsp_*): exactly one item per request item, in order. Both channels use
// valid/ready. The csr_* port writes own_ip (index 0) with no wait; a write
// to index 1 is ignored, as no own_mac is kept. Write only while idle.
//
// The front classifies each item in the accept cycle (header checks, reply
// decision) and pushes a command into a two-entry queue. The back scans the
// table through one RAM read port, one entry per cycle, stopping at a hit.
// A table item's response time is set by the serial scan; a dropped packet
// or an unused op skips the scan and goes straight to S_POST.
// The back works on one item at a time; the queue keeps accepting while it
// is busy, and the response register holds a result while the receiver
// stalls, so the back runs ahead by one item before it blocks.
// Reset clears own_ip, all valid bits, the queue and the response valid bit;
// no clearing pass is needed.
module arp_cache_and_responder
   import arpc_pkg::*;
#(
   parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [10:0]           req_pkt_len,
   input  logic [MAC_W-1:0]      req_eth_src,
   input  logic [15:0]           req_hw_type,
   input  logic [15:0]           req_proto_type,
   input  logic [15:0]           req_arp_opcode,
   input  logic [MAC_W-1:0]      req_sender_mac,
   input  logic [IP_W-1:0]       req_sender_ip,
   input  logic [IP_W-1:0]       req_target_ip,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_drop_code,
   output logic                  rsp_table_ok,
   output logic                  rsp_reply_send,
   output logic [MAC_W-1:0]      rsp_reply_dest_mac,
   output logic [MAC_W-1:0]      rsp_reply_target_mac,
   output logic [IP_W-1:0]       rsp_reply_target_ip,
   output logic                  rsp_lookup_hit,
   output logic [MAC_W-1:0]      rsp_lookup_mac,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic       q_full;
   logic       q_push;
   cmd_type    q_push_data;
   logic       q_pop;
   cmd_type    q_pop_data;
   logic       q_not_empty;
   result_type rsp_data;

   // Classify and push commands
   arpc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_pkt_len    (req_pkt_len),
      .req_eth_src    (req_eth_src),
      .req_hw_type    (req_hw_type),
      .req_proto_type (req_proto_type),
      .req_arp_opcode (req_arp_opcode),
      .req_sender_mac (req_sender_mac),
      .req_sender_ip  (req_sender_ip),
      .req_target_ip  (req_target_ip),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata[IP_W-1:0]),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_push_data)
   );

   // Decouple front from back
   arpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   // Scan the table, update bindings, and register the response
   arpc_back #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd_data  (q_pop_data),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_drop_code        = rsp_data.drop_code;
   assign rsp_table_ok         = rsp_data.table_ok;
   assign rsp_reply_send       = rsp_data.reply_send;
   assign rsp_reply_dest_mac   = rsp_data.reply_dest_mac;
   assign rsp_reply_target_mac = rsp_data.reply_target_mac;
   assign rsp_reply_target_ip  = rsp_data.reply_target_ip;
   assign rsp_lookup_hit       = rsp_data.lookup_hit;
   assign rsp_lookup_mac       = rsp_data.lookup_mac;

endmodule

FILE: hdl/arpc_ram.sv
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/arpc_front.sv
module arpc_front
   import arpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [10:0]          req_pkt_len,
   input  logic [MAC_W-1:0]     req_eth_src,
   input  logic [15:0]          req_hw_type,
   input  logic [15:0]          req_proto_type,
   input  logic [15:0]          req_arp_opcode,
   input  logic [MAC_W-1:0]     req_sender_mac,
   input  logic [IP_W-1:0]      req_sender_ip,
   input  logic [IP_W-1:0]      req_target_ip,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [IP_W-1:0]      csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output cmd_type              q_data
);

   logic [IP_W-1:0] own_ip_ff;
   logic [IP_W-1:0] own_ip_in;

   always_comb begin
      own_ip_in = own_ip_ff;
      if (csr_we && csr_index == CSR_OWN_IP) begin
         own_ip_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
      end else begin
         own_ip_ff <= own_ip_in;
      end
   end

   // Classify: header checks in priority order, then decide table work and reply
   always_comb begin
      q_data        = '0;
      q_data.kind   = CMD_FIXED;
      q_data.key_ip = req_sender_ip;
      q_data.mac    = req_sender_mac;
      unique case (req_op)
         OP_RECEIVE: begin
            priority if (req_pkt_len < HDR_BYTES) begin
               q_data.base.drop_code = DROP_RUNT;
            end else if (req_hw_type != HTYPE_ETH) begin
               q_data.base.drop_code = DROP_HTYPE;
            end else if (req_proto_type != PTYPE_IPV4) begin
               q_data.base.drop_code = DROP_PTYPE;
            end else begin
               q_data.kind = CMD_STORE;
               if (req_target_ip == own_ip_ff && req_arp_opcode == OPC_REQUEST) begin
                  q_data.base.reply_send       = 1'b1;
                  q_data.base.reply_dest_mac   = req_eth_src;
                  q_data.base.reply_target_mac = req_sender_mac;
                  q_data.base.reply_target_ip  = req_sender_ip;
               end
            end
         end
         OP_LOOKUP: q_data.kind = CMD_LOOKUP;
         OP_INSERT: q_data.kind = CMD_STORE;
         OP_UNUSED: q_data.kind = CMD_FIXED;
         default:   q_data.kind = CMD_FIXED;
      endcase
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

FILE: hdl/arpc_queue.sv
module arpc_queue
   import arpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    not_empty
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/arpc_back.sv
module arpc_back
   import arpc_pkg::*;
#(
   parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd_data,
   output logic       cmd_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CW = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CW-1:0] N_CNT    = CW'(CACHE_ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_POST = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [CW-1:0]           issue_ff, issue_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IW-1:0]           chk_idx_ff, chk_idx_in;
   logic                    free_fnd_ff, free_fnd_in;
   logic [IW-1:0]           free_idx_ff, free_idx_in;
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   result_type              res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;

   logic                    ram_we;
   logic [IW-1:0]           ram_waddr;
   logic [ENTRY_W-1:0]      ram_rdata;
   logic [IP_W-1:0]         rd_ip;
   logic [MAC_W-1:0]        rd_mac;
   logic                    hit, is_free, new_fnd;
   logic [IW-1:0]           new_idx;

   arpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({cmd_ff.key_ip, cmd_ff.mac}),
      .raddr (issue_ff[IW-1:0]),
      .rdata (ram_rdata)
   );

   assign rd_ip  = ram_rdata[ENTRY_W-1:MAC_W];
   assign rd_mac = ram_rdata[MAC_W-1:0];

   assign hit     = chk_vld_ff && valid_ff[chk_idx_ff] && (rd_ip == cmd_ff.key_ip);
   assign is_free = chk_vld_ff && !valid_ff[chk_idx_ff];
   assign new_fnd = free_fnd_ff || is_free;
   assign new_idx = free_fnd_ff ? free_idx_ff : chk_idx_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = chk_idx_ff;
      cmd_pop      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd_data;
               res_in      = cmd_data.base;
               issue_in    = '0;
               free_fnd_in = 1'b0;
               state_in    = (cmd_data.kind == CMD_FIXED) ? S_POST : S_SCAN;
            end
         end
         S_SCAN: begin
            // Issue one read a cycle, check the entry read the cycle before
            if (issue_ff < N_CNT) begin
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IW-1:0];
               issue_in   = issue_ff + 1'b1;
            end
            free_fnd_in = new_fnd;
            free_idx_in = new_idx;
            if (hit) begin
               chk_vld_in = 1'b0;
               state_in   = S_POST;
               if (cmd_ff.kind == CMD_LOOKUP) begin
                  res_in.lookup_hit = 1'b1;
                  res_in.lookup_mac = rd_mac;
               end else begin
                  ram_we          = 1'b1;
                  ram_waddr       = chk_idx_ff;
                  res_in.table_ok = 1'b1;
               end
            end else if (chk_vld_ff && chk_idx_ff == LAST_IDX) begin
               chk_vld_in = 1'b0;
               state_in   = S_POST;
               if (cmd_ff.kind == CMD_STORE && new_fnd) begin
                  ram_we            = 1'b1;
                  ram_waddr         = new_idx;
                  valid_in[new_idx] = 1'b1;
                  res_in.table_ok   = 1'b1;
               end
            end
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
         free_fnd_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         free_fnd_ff  <= free_fnd_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      chk_idx_ff  <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/arpc_checker.sv
module arpc_checker
   import arpc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_drop_code,
   input logic             rsp_table_ok,
   input logic             rsp_reply_send,
   input logic             rsp_lookup_hit,
   input logic [MAC_W-1:0] rsp_lookup_mac,
   input logic [IP_W-1:0]  rsp_reply_target_ip
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lookup_mac)
         && $stable(rsp_reply_target_ip) && $stable(rsp_drop_code))
      else $error("stalled response changed");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drop_code != DROP_NONE
         |-> !rsp_table_ok && !rsp_reply_send && !rsp_lookup_hit)
      else $error("dropped packet reports table or reply activity");

   a_lookup_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lookup_hit |-> !rsp_table_ok && !rsp_reply_send)
      else $error("lookup hit mixed with store or reply");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lookup_hit |-> rsp_lookup_mac == '0)
      else $error("nonzero MAC on lookup miss");

endmodule

bind arp_cache_and_responder arpc_checker u_chk (.*);
